### rtl/bdbes_pkg.sv
// Shared types, codes and constants of the bus decoder with big-endian store.
// No dependencies; the core and the decoder refer to this package by scoped names.
`default_nettype none

package bdbes_pkg;

  localparam logic [32:0] LOW_WINDOW_BYTES    = 33'h0_0180_0000;
  localparam logic [32:0] SECOND_WINDOW_BYTES = 33'h0_0400_0000;
  localparam int          GRANULE_SHIFT       = 5;   // 32-byte reservation granule

  typedef enum logic [1:0] {
    ACT_READ    = 2'd0,
    ACT_WRITE   = 2'd1,
    ACT_RESERVE = 2'd2,
    ACT_RELEASE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_RAM1    = 2'd0,
    REG_RAM2    = 2'd1,
    REG_IO      = 2'd2,
    REG_INVALID = 2'd3
  } region_t;

  typedef enum logic [2:0] {
    CFG_MEM2_PHYS      = 3'd0,
    CFG_MEM1_CACHED    = 3'd1,
    CFG_MEM1_UNCACHED  = 3'd2,
    CFG_MEM2_CACHED    = 3'd3,
    CFG_MEM2_UNCACHED  = 3'd4,
    CFG_IO_FIRST       = 3'd5,
    CFG_IO_SECOND      = 3'd6,
    CFG_IO_WINDOW      = 3'd7
  } cfg_index_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_ACCESS,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [31:0] mem2_phys_base;
    logic [31:0] mem1_cached_base;
    logic [31:0] mem1_uncached_base;
    logic [31:0] mem2_cached_base;
    logic [31:0] mem2_uncached_base;
    logic [31:0] io_first_base;
    logic [31:0] io_second_base;
    logic [24:0] io_window_bytes;
  } cfg_t;

  typedef struct packed {
    region_t     region;
    logic [31:0] offset;
  } decoded_t;

  function automatic logic in_window(input logic [31:0] a, input logic [31:0] base,
                                     input logic [32:0] len);
    logic [31:0] diff;
    diff = a - base;
    return (a >= base) && ({1'b0, diff} < len);
  endfunction

endpackage

`default_nettype wire

### rtl/bus_decode_big_endian_store_core.sv
// Bus decoder with two big-endian byte RAMs and a load-reservation monitor.
// Each request passes four stages: capture at acceptance, address decode (request
// and reserved address in parallel), memory access with reservation update, and
// read-data assembly from the registered bank outputs into the output register.
// The next request is taken the cycle after the result is loaded, so a request is
// not accepted while the previous one is in flight; a result left waiting in the
// output register holds the assembly stage until it is taken.
// Depends on bdbes_pkg, bdbes_decode and bdbes_ram.
`default_nettype none

module bus_decode_big_endian_store_core #(
  parameter int FIRST_RAM_BYTES  = 65536,
  parameter int SECOND_RAM_BYTES = 65536
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // action[1:0], address[33:2], size_code[35:34], write_data[99:36], zero fill
  input  wire logic [103:0] s_tdata,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // read_data[63:0], region[65:64], region_offset[97:66],
  // reservation_cleared[98], reservation_held[99], out_of_store[100], zero fill
  output logic [103:0]      m_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  localparam int AW1 = $clog2((FIRST_RAM_BYTES + 7) / 8) + 3;
  localparam int AW2 = $clog2((SECOND_RAM_BYTES + 7) / 8) + 3;

  bdbes_pkg::cfg_t     cfg;
  bdbes_pkg::state_t   state, state_next;

  bdbes_pkg::action_t  action;
  logic [31:0]         address;
  logic [1:0]          size_code;
  logic [63:0]         write_data;

  bdbes_pkg::decoded_t dec_item, dec_rsv;
  bdbes_pkg::decoded_t item, rsv;

  logic [31:0]         reserved_address;
  logic                reserved_valid;

  bdbes_pkg::region_t  res_region;
  logic [31:0]         res_offset;
  logic                res_cleared;
  logic                res_held;
  logic                res_oos;
  logic                res_rd1;
  logic                res_rd2;

  logic                load_in;
  logic                do_access;
  logic                load_out;

  // access stage
  bdbes_pkg::region_t  acc_region;
  logic [31:0]         acc_offset;
  logic [32:0]         width;
  logic [32:0]         span_last;
  logic [32:0]         span_end;
  logic                oos;
  logic                clear_hit;
  logic                ram1_en, ram2_en;
  logic [63:0]         rdata1, rdata2;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mem2_phys_base     <= 32'h1000_0000;
      cfg.mem1_cached_base   <= 32'h8000_0000;
      cfg.mem1_uncached_base <= 32'hC000_0000;
      cfg.mem2_cached_base   <= 32'h9000_0000;
      cfg.mem2_uncached_base <= 32'hD000_0000;
      cfg.io_first_base      <= 32'hCC00_0000;
      cfg.io_second_base     <= 32'hCD00_0000;
      cfg.io_window_bytes    <= 25'h001_0000;
    end else if (cfg_we) begin
      unique case (bdbes_pkg::cfg_index_t'(cfg_index))
        bdbes_pkg::CFG_MEM2_PHYS:     cfg.mem2_phys_base     <= cfg_data;
        bdbes_pkg::CFG_MEM1_CACHED:   cfg.mem1_cached_base   <= cfg_data;
        bdbes_pkg::CFG_MEM1_UNCACHED: cfg.mem1_uncached_base <= cfg_data;
        bdbes_pkg::CFG_MEM2_CACHED:   cfg.mem2_cached_base   <= cfg_data;
        bdbes_pkg::CFG_MEM2_UNCACHED: cfg.mem2_uncached_base <= cfg_data;
        bdbes_pkg::CFG_IO_FIRST:      cfg.io_first_base      <= cfg_data;
        bdbes_pkg::CFG_IO_SECOND:     cfg.io_second_base     <= cfg_data;
        bdbes_pkg::CFG_IO_WINDOW:     cfg.io_window_bytes    <= cfg_data[24:0];
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bdbes_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    load_in    = 1'b0;
    do_access  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      bdbes_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          load_in    = 1'b1;
          state_next = bdbes_pkg::S_DECODE;
        end
      end
      bdbes_pkg::S_DECODE: begin
        state_next = bdbes_pkg::S_ACCESS;
      end
      bdbes_pkg::S_ACCESS: begin
        do_access  = 1'b1;
        state_next = bdbes_pkg::S_RESULT;
      end
      bdbes_pkg::S_RESULT: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = bdbes_pkg::S_IDLE;
        end
      end
    endcase
  end

  // capture
  always_ff @(posedge clk) begin
    if (load_in) begin
      action     <= bdbes_pkg::action_t'(s_tdata[1:0]);
      address    <= s_tdata[33:2];
      size_code  <= s_tdata[35:34];
      write_data <= s_tdata[99:36];
    end
  end

  // decode
  bdbes_decode u_dec_item (
    .cfg     (cfg),
    .address (address),
    .dec     (dec_item)
  );

  bdbes_decode u_dec_rsv (
    .cfg     (cfg),
    .address (reserved_address),
    .dec     (dec_rsv)
  );

  always_ff @(posedge clk) begin
    if (state == bdbes_pkg::S_DECODE) begin
      item <= dec_item;
      rsv  <= dec_rsv;
    end
  end

  // access
  always_comb begin
    acc_region = item.region;
    acc_offset = item.offset;
    if (item.region == bdbes_pkg::REG_IO && size_code == 2'd3) begin
      acc_region = bdbes_pkg::REG_INVALID;
      acc_offset = '0;
    end
    width     = 33'd1 << size_code;
    span_end  = {1'b0, acc_offset} + width;
    span_last = {1'b0, item.offset} + width - 33'd1;
    oos       = 1'b0;
    if (acc_region == bdbes_pkg::REG_RAM1) begin
      oos = span_end > 33'(FIRST_RAM_BYTES);
    end else if (acc_region == bdbes_pkg::REG_RAM2) begin
      oos = span_end > 33'(SECOND_RAM_BYTES);
    end
    clear_hit = (action == bdbes_pkg::ACT_WRITE) && reserved_valid &&
                (rsv.region == item.region) &&
                ((rsv.offset >> bdbes_pkg::GRANULE_SHIFT) >=
                 (item.offset >> bdbes_pkg::GRANULE_SHIFT)) &&
                ({1'b0, rsv.offset >> bdbes_pkg::GRANULE_SHIFT} <=
                 (span_last >> bdbes_pkg::GRANULE_SHIFT));
    ram1_en = do_access && !oos && acc_region == bdbes_pkg::REG_RAM1 &&
              (action == bdbes_pkg::ACT_READ || action == bdbes_pkg::ACT_WRITE);
    ram2_en = do_access && !oos && acc_region == bdbes_pkg::REG_RAM2 &&
              (action == bdbes_pkg::ACT_READ || action == bdbes_pkg::ACT_WRITE);
  end

  bdbes_ram #(.BYTES(FIRST_RAM_BYTES)) u_ram1 (
    .clk       (clk),
    .en        (ram1_en),
    .we        (action == bdbes_pkg::ACT_WRITE),
    .offset    (acc_offset[AW1-1:0]),
    .size_code (size_code),
    .wdata     (write_data),
    .rdata     (rdata1)
  );

  bdbes_ram #(.BYTES(SECOND_RAM_BYTES)) u_ram2 (
    .clk       (clk),
    .en        (ram2_en),
    .we        (action == bdbes_pkg::ACT_WRITE),
    .offset    (acc_offset[AW2-1:0]),
    .size_code (size_code),
    .wdata     (write_data),
    .rdata     (rdata2)
  );

  // reservation monitor
  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_address <= '0;
      reserved_valid   <= 1'b0;
    end else if (do_access) begin
      case (action)
        bdbes_pkg::ACT_RESERVE: begin
          reserved_address <= address;
          reserved_valid   <= 1'b1;
        end
        bdbes_pkg::ACT_RELEASE: begin
          reserved_valid <= 1'b0;
        end
        default: begin
          if (clear_hit) begin
            reserved_valid <= 1'b0;
          end
        end
      endcase
    end
  end

  // hold result fields for the assembly cycle
  always_ff @(posedge clk) begin
    if (do_access) begin
      res_cleared <= clear_hit;
      res_rd1     <= ram1_en && action == bdbes_pkg::ACT_READ;
      res_rd2     <= ram2_en && action == bdbes_pkg::ACT_READ;
      if (action == bdbes_pkg::ACT_RESERVE || action == bdbes_pkg::ACT_RELEASE) begin
        res_region <= item.region;
        res_offset <= item.offset;
        res_oos    <= 1'b0;
        res_held   <= (action == bdbes_pkg::ACT_RESERVE);
      end else begin
        res_region <= acc_region;
        res_offset <= acc_offset;
        res_oos    <= oos;
        res_held   <= reserved_valid && !clear_hit;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata[63:0]    <= res_rd1 ? rdata1 : (res_rd2 ? rdata2 : 64'd0);
      m_tdata[65:64]   <= res_region;
      m_tdata[97:66]   <= res_offset;
      m_tdata[98]      <= res_cleared;
      m_tdata[99]      <= res_held;
      m_tdata[100]     <= res_oos;
      m_tdata[103:101] <= '0;
    end
  end

endmodule

`default_nettype wire

### rtl/bdbes_decode.sv
// Address decoder: maps a bus address to a region and an offset by window priority.
// Depends on bdbes_pkg for the configuration struct, region codes and window test.
`default_nettype none

module bdbes_decode (
  input  wire bdbes_pkg::cfg_t     cfg,
  input  wire logic [31:0]         address,
  output bdbes_pkg::decoded_t      dec
);

  always_comb begin
    dec.region = bdbes_pkg::REG_INVALID;
    dec.offset = '0;
    if ({1'b0, address} < bdbes_pkg::LOW_WINDOW_BYTES) begin
      dec.region = bdbes_pkg::REG_RAM1;
      dec.offset = address;
    end else if (bdbes_pkg::in_window(address, cfg.mem2_phys_base,
                                      bdbes_pkg::SECOND_WINDOW_BYTES)) begin
      dec.region = bdbes_pkg::REG_RAM2;
      dec.offset = address - cfg.mem2_phys_base;
    end else if (bdbes_pkg::in_window(address, cfg.mem1_cached_base,
                                      bdbes_pkg::LOW_WINDOW_BYTES)) begin
      dec.region = bdbes_pkg::REG_RAM1;
      dec.offset = address - cfg.mem1_cached_base;
    end else if (bdbes_pkg::in_window(address, cfg.mem1_uncached_base,
                                      bdbes_pkg::LOW_WINDOW_BYTES)) begin
      dec.region = bdbes_pkg::REG_RAM1;
      dec.offset = address - cfg.mem1_uncached_base;
    end else if (bdbes_pkg::in_window(address, cfg.mem2_cached_base,
                                      bdbes_pkg::SECOND_WINDOW_BYTES)) begin
      dec.region = bdbes_pkg::REG_RAM2;
      dec.offset = address - cfg.mem2_cached_base;
    end else if (bdbes_pkg::in_window(address, cfg.mem2_uncached_base,
                                      bdbes_pkg::SECOND_WINDOW_BYTES)) begin
      dec.region = bdbes_pkg::REG_RAM2;
      dec.offset = address - cfg.mem2_uncached_base;
    end else if (bdbes_pkg::in_window(address, cfg.io_first_base,
                                      {8'd0, cfg.io_window_bytes}) ||
                 bdbes_pkg::in_window(address, cfg.io_second_base,
                                      {8'd0, cfg.io_window_bytes})) begin
      dec.region = bdbes_pkg::REG_IO;
      dec.offset = address;
    end
  end

endmodule

`default_nettype wire

### rtl/bdbes_ram.sv
// Byte RAM split into eight lane banks so an unaligned access of up to 8 bytes
// touches each bank once; big-endian byte order. Depends on nothing else.
`default_nettype none

module bdbes_ram #(
  parameter  int BYTES = 65536,
  localparam int ROWS  = (BYTES + 7) / 8,
  localparam int RW    = $clog2(ROWS),
  localparam int AW    = RW + 3
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic          we,
  input  wire logic [AW-1:0] offset,
  input  wire logic [1:0]    size_code,
  input  wire logic [63:0]   wdata,
  output logic [63:0]        rdata
);

  logic [2:0]    lane0;
  logic [2:0]    wm1;
  logic [RW-1:0] row_base;
  logic [RW-1:0] row   [8];
  logic          act   [8];
  logic [7:0]    wbyte [8];
  logic [7:0]    q     [8];
  logic [2:0]    lane0_q;
  logic [2:0]    wm1_q;

  assign lane0    = offset[2:0];
  assign wm1      = 3'((4'd1 << size_code) - 4'd1);
  assign row_base = offset[AW-1:3];

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      logic [2:0] k;
      logic [2:0] j;
      k        = 3'(b) - lane0;
      j        = wm1 - k;
      act[b]   = (k <= wm1);
      row[b]   = row_base + RW'(3'(b) < lane0);
      wbyte[b] = wdata[{j, 3'b000} +: 8];
    end
  end

  for (genvar g = 0; g < 8; g++) begin : g_bank
    logic [7:0] mem [ROWS];

    always_ff @(posedge clk) begin
      if (en && we && act[g]) begin
        mem[row[g]] <= wbyte[g];
      end
      if (en && !we) begin
        q[g] <= mem[row[g]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && !we) begin
      lane0_q <= lane0;
      wm1_q   <= wm1;
    end
  end

  always_comb begin
    rdata = '0;
    for (int j = 0; j < 8; j++) begin
      logic [2:0] k;
      k = wm1_q - 3'(j);
      if (3'(j) <= wm1_q) begin
        rdata[8*j +: 8] = q[3'(lane0_q + k)];
      end
    end
  end

endmodule

`default_nettype wire
